### rtl/sto_pkg.sv
`timescale 1ns / 1ps

package sto_pkg;

  // Command codes
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;
  localparam logic [1:0] KIND_EXP = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_SCHEDULED = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  localparam int ID_W       = 4;
  localparam int DELTA_W    = 32;
  // Max expiries reported per tick
  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = $clog2(RESULT_CAP);

  typedef struct packed {
    logic [1:0]         cmd;
    logic [ID_W-1:0]    timer_id;
    logic [DELTA_W-1:0] delta;
  } cmd_req_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] expired_id;
    logic [1:0]      status;
    logic            last;
  } res_data_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] id;
  } cell_ctrl_t;

endpackage

### rtl/sto_cell.sv
`timescale 1ns / 1ps

// One queue slot. Inserts shift right, deletes and pops shift left.
module sto_cell #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sto_pkg::cell_ctrl_t       ctrl,
  input  logic [TIME_WIDTH-1:0]     new_expiry,
  input  logic                      prev_keep,
  input  logic                      prev_valid,
  input  logic [sto_pkg::ID_W-1:0]  prev_timer,
  input  logic [TIME_WIDTH-1:0]     prev_expiry,
  input  logic                      next_valid,
  input  logic [sto_pkg::ID_W-1:0]  next_timer,
  input  logic [TIME_WIDTH-1:0]     next_expiry,
  input  logic                      del_in,
  output logic                      valid,
  output logic [sto_pkg::ID_W-1:0]  timer,
  output logic [TIME_WIDTH-1:0]     expiry,
  output logic                      keep,
  output logic                      del_out
);

  logic                     valid_next;
  logic [sto_pkg::ID_W-1:0] timer_next;
  logic [TIME_WIDTH-1:0]    expiry_next;

  // Stays put on insert: equal expiry keeps insertion order
  assign keep    = valid && (expiry <= new_expiry);
  assign del_out = del_in || (valid && (timer == ctrl.id));

  always_comb begin
    valid_next  = valid;
    timer_next  = timer;
    expiry_next = expiry;
    unique case (ctrl.op)
      sto_pkg::CELL_HOLD: begin
      end
      sto_pkg::CELL_INSERT: begin
        if (!keep) begin
          if (prev_keep) begin
            valid_next  = 1'b1;
            timer_next  = ctrl.id;
            expiry_next = new_expiry;
          end else begin
            valid_next  = prev_valid;
            timer_next  = prev_timer;
            expiry_next = prev_expiry;
          end
        end
      end
      sto_pkg::CELL_DELETE: begin
        if (del_out) begin
          valid_next  = next_valid;
          timer_next  = next_timer;
          expiry_next = next_expiry;
        end
      end
      sto_pkg::CELL_POP: begin
        valid_next  = next_valid;
        timer_next  = next_timer;
        expiry_next = next_expiry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    timer  <= timer_next;
    expiry <= expiry_next;
  end

endmodule

### rtl/sorted_timeout_queue_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload                Handshake
// cmd       in         sto_pkg::cmd_req_t     cmd_valid / cmd_ready
// res       out        sto_pkg::res_data_t    res_valid / res_ready
//
// On add and delete the slot cells update in place and the acknowledge
// lands in the output register. A tick steps time, then pops expired
// entries off the head (at most 16), each only when the output is free,
// or returns to idle with no result when nothing is due.
// Synchronous reset empties the queue and zeroes the time counter.
// A stalled result holds the sequencer; cmd_ready drops until it drains.
module sorted_timeout_queue_unit #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  sto_pkg::cmd_req_t   cmd_req,
  output logic                res_valid,
  input  logic                res_ready,
  output sto_pkg::res_data_t  res_data
);

  localparam int IDX_W = $clog2(NUM_TIMERS);
  localparam int EXT_W = (IDX_W > sto_pkg::ID_W) ? IDX_W : sto_pkg::ID_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_t;

  state_t state, state_next;

  // Slot chain wiring
  logic                     c_valid  [NUM_TIMERS];
  logic [sto_pkg::ID_W-1:0] c_timer  [NUM_TIMERS];
  logic [TIME_WIDTH-1:0]    c_expiry [NUM_TIMERS];
  logic                     c_keep   [NUM_TIMERS];
  logic                     c_del    [NUM_TIMERS];
  logic                     p_keep   [NUM_TIMERS];
  logic                     p_valid  [NUM_TIMERS];
  logic [sto_pkg::ID_W-1:0] p_timer  [NUM_TIMERS];
  logic [TIME_WIDTH-1:0]    p_expiry [NUM_TIMERS];
  logic                     n_valid  [NUM_TIMERS];
  logic [sto_pkg::ID_W-1:0] n_timer  [NUM_TIMERS];
  logic [TIME_WIDTH-1:0]    n_expiry [NUM_TIMERS];
  logic                     d_in     [NUM_TIMERS];

  sto_pkg::cell_ctrl_t   ctrl;
  logic [TIME_WIDTH-1:0] add_expiry;
  logic [TIME_WIDTH:0]   add_sum;

  logic [TIME_WIDTH-1:0] now_time, now_time_next;
  logic [NUM_TIMERS-1:0] scheduled, scheduled_next;
  logic [sto_pkg::CNT_W-1:0] cnt, cnt_next;

  logic                  res_valid_next;
  sto_pkg::res_data_t    res_data_next;
  logic                  res_load;

  logic [EXT_W-1:0] req_id_ext, head_id_ext;
  logic [IDX_W-1:0] req_idx, head_idx;
  logic             id_in_range;
  logic             out_free;
  logic             accept;
  logic             head_due, next_due, pop_last;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign p_keep[gi]   = 1'b1;
        assign p_valid[gi]  = 1'b0;
        assign p_timer[gi]  = '0;
        assign p_expiry[gi] = '0;
        assign d_in[gi]     = 1'b0;
      end else begin : g_rest
        assign p_keep[gi]   = c_keep[gi-1];
        assign p_valid[gi]  = c_valid[gi-1];
        assign p_timer[gi]  = c_timer[gi-1];
        assign p_expiry[gi] = c_expiry[gi-1];
        assign d_in[gi]     = c_del[gi-1];
      end
      if (gi == NUM_TIMERS - 1) begin : g_tail
        assign n_valid[gi]  = 1'b0;
        assign n_timer[gi]  = '0;
        assign n_expiry[gi] = '0;
      end else begin : g_body
        assign n_valid[gi]  = c_valid[gi+1];
        assign n_timer[gi]  = c_timer[gi+1];
        assign n_expiry[gi] = c_expiry[gi+1];
      end

      sto_cell #(
        .TIME_WIDTH (TIME_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .new_expiry  (add_expiry),
        .prev_keep   (p_keep[gi]),
        .prev_valid  (p_valid[gi]),
        .prev_timer  (p_timer[gi]),
        .prev_expiry (p_expiry[gi]),
        .next_valid  (n_valid[gi]),
        .next_timer  (n_timer[gi]),
        .next_expiry (n_expiry[gi]),
        .del_in      (d_in[gi]),
        .valid       (c_valid[gi]),
        .timer       (c_timer[gi]),
        .expiry      (c_expiry[gi]),
        .keep        (c_keep[gi]),
        .del_out     (c_del[gi])
      );
    end
  endgenerate

  // Saturating expiry of a new entry
  assign add_sum    = {1'b0, now_time} + (TIME_WIDTH+1)'(cmd_req.delta);
  assign add_expiry = add_sum[TIME_WIDTH] ? '1 : add_sum[TIME_WIDTH-1:0];

  assign req_id_ext  = EXT_W'(cmd_req.timer_id);
  assign req_idx     = req_id_ext[IDX_W-1:0];
  assign head_id_ext = EXT_W'(c_timer[0]);
  assign head_idx    = head_id_ext[IDX_W-1:0];
  assign id_in_range = 32'(cmd_req.timer_id) < NUM_TIMERS;

  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == ST_IDLE) && out_free;
  assign accept    = cmd_valid && cmd_ready;

  // Head pops while due; stop at cap or when the next slot is not yet due
  assign head_due = c_valid[0] && (c_expiry[0] <= now_time);
  assign next_due = c_valid[1] && (c_expiry[1] <= now_time);
  assign pop_last = !next_due || (cnt == sto_pkg::CNT_W'(sto_pkg::RESULT_CAP - 1));

  always_comb begin
    state_next     = state;
    now_time_next  = now_time;
    scheduled_next = scheduled;
    cnt_next       = cnt;
    ctrl.op        = sto_pkg::CELL_HOLD;
    ctrl.id        = cmd_req.timer_id;
    res_load       = 1'b0;
    res_data_next  = res_data;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (cmd_req.cmd)
            sto_pkg::CMD_ADD: begin
              res_load                 = 1'b1;
              res_data_next.kind       = sto_pkg::KIND_ADD;
              res_data_next.expired_id = cmd_req.timer_id;
              res_data_next.last       = 1'b1;
              if (!id_in_range) begin
                res_data_next.status = sto_pkg::STAT_NOT_FOUND;
              end else if (scheduled[req_idx] || c_valid[NUM_TIMERS-1]) begin
                res_data_next.status = sto_pkg::STAT_SCHEDULED;
              end else begin
                res_data_next.status    = sto_pkg::STAT_OK;
                ctrl.op                 = sto_pkg::CELL_INSERT;
                scheduled_next[req_idx] = 1'b1;
              end
            end
            sto_pkg::CMD_DEL: begin
              res_load                 = 1'b1;
              res_data_next.kind       = sto_pkg::KIND_DEL;
              res_data_next.expired_id = cmd_req.timer_id;
              res_data_next.last       = 1'b1;
              if (id_in_range && scheduled[req_idx]) begin
                res_data_next.status    = sto_pkg::STAT_OK;
                ctrl.op                 = sto_pkg::CELL_DELETE;
                scheduled_next[req_idx] = 1'b0;
              end else begin
                res_data_next.status = sto_pkg::STAT_NOT_FOUND;
              end
            end
            sto_pkg::CMD_TICK: begin
              now_time_next = (&now_time) ? now_time : now_time + 1'b1;
              cnt_next      = '0;
              state_next    = ST_POP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (!head_due) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          ctrl.op                  = sto_pkg::CELL_POP;
          scheduled_next[head_idx] = 1'b0;
          res_load                 = 1'b1;
          res_data_next.kind       = sto_pkg::KIND_EXP;
          res_data_next.expired_id = c_timer[0];
          res_data_next.status     = sto_pkg::STAT_OK;
          res_data_next.last       = pop_last;
          cnt_next                 = cnt + 1'b1;
          if (pop_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (res_valid && res_ready) begin
      res_valid_next = 1'b0;
    end
    if (res_load) begin
      res_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now_time  <= '0;
      scheduled <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      now_time  <= now_time_next;
      scheduled <= scheduled_next;
      cnt       <= cnt_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_data <= res_data_next;
  end

endmodule

### rtl/sto_check.sv
`timescale 1ns / 1ps

module sto_check (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input sto_pkg::cmd_req_t  cmd_req,
  input logic               res_valid,
  input logic               res_ready,
  input sto_pkg::res_data_t res_data
);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result dropped or changed while stalled");

  // Add and delete are acknowledged in the next cycle, single and last
  a_ack_next: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready &&
      (cmd_req.cmd == sto_pkg::CMD_ADD || cmd_req.cmd == sto_pkg::CMD_DEL)
    |=> res_valid && res_data.last && res_data.kind == $past(cmd_req.cmd))
    else $error("missing acknowledge");

  // Acknowledge echoes the requested id
  a_ack_id: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready &&
      (cmd_req.cmd == sto_pkg::CMD_ADD || cmd_req.cmd == sto_pkg::CMD_DEL)
    |=> res_data.expired_id == $past(cmd_req.timer_id))
    else $error("acknowledge id mismatch");

  // Expiry results always carry ok status
  a_exp_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind == sto_pkg::KIND_EXP |-> res_data.status == sto_pkg::STAT_OK)
    else $error("expiry with nonzero status");

endmodule

bind sorted_timeout_queue_unit sto_check u_sto_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd_req   (cmd_req),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);

### dv/sorted_timeout_queue_unit_tb.sv
`timescale 1ns / 1ps

module sorted_timeout_queue_unit_tb;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_W = 48;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  // Spare command code, dropped by the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [sto_pkg::ID_W-1:0] id;
    logic [TIME_W-1:0]        expiry;
  } timer_entry_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  sto_pkg::cmd_req_t  cmd_req = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  sto_pkg::res_data_t res_data;

  // Shadow of the timer queue
  timer_entry_t      timer_list[$];
  bit                armed[NUM_TIMERS];
  logic [TIME_W-1:0] clock_now = '0;

  sto_pkg::res_data_t expected_results[$];
  sto_pkg::cmd_req_t  cmd_backlog[$];

  int mismatches = 0;
  int accepted = 0;
  int checked = 0;
  int expiries_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  int calm_left = 0;
  bit calm = 1'b0;

  sorted_timeout_queue_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_req  (cmd_req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void expect_result(logic [1:0] kind, logic [sto_pkg::ID_W-1:0] id,
                                        logic [1:0] status, logic last);
    sto_pkg::res_data_t r;
    r.kind = kind;
    r.expired_id = id;
    r.status = status;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic logic [1:0] schedule_timer(logic [sto_pkg::ID_W-1:0] id,
                                                logic [sto_pkg::DELTA_W-1:0] delta);
    logic [TIME_W:0] sum;
    timer_entry_t    e;
    int              pos;
    if (int'(id) >= NUM_TIMERS) return sto_pkg::STAT_NOT_FOUND;
    if (armed[id]) return sto_pkg::STAT_SCHEDULED;
    sum = {1'b0, clock_now} + (TIME_W+1)'(delta);
    if (sum > {1'b0, TIME_MAX}) sum = {1'b0, TIME_MAX};
    if (timer_list.size() >= NUM_TIMERS) return sto_pkg::STAT_SCHEDULED;
    // equal expiry goes behind existing entries
    pos = 0;
    while (pos < timer_list.size() && timer_list[pos].expiry <= sum[TIME_W-1:0]) pos++;
    e.id = id;
    e.expiry = sum[TIME_W-1:0];
    timer_list.insert(pos, e);
    armed[id] = 1'b1;
    return sto_pkg::STAT_OK;
  endfunction

  function automatic logic [1:0] cancel_timer(logic [sto_pkg::ID_W-1:0] id);
    if (int'(id) >= NUM_TIMERS || !armed[id]) return sto_pkg::STAT_NOT_FOUND;
    armed[id] = 1'b0;
    foreach (timer_list[i]) begin
      if (timer_list[i].id == id) begin
        timer_list.delete(i);
        return sto_pkg::STAT_OK;
      end
    end
    return sto_pkg::STAT_NOT_FOUND;
  endfunction

  function automatic void apply_command(sto_pkg::cmd_req_t c);
    int fired;
    fired = 0;
    case (c.cmd)
      sto_pkg::CMD_ADD: begin
        expect_result(sto_pkg::KIND_ADD, c.timer_id,
                      schedule_timer(c.timer_id, c.delta), 1'b1);
      end
      sto_pkg::CMD_DEL: begin
        expect_result(sto_pkg::KIND_DEL, c.timer_id, cancel_timer(c.timer_id), 1'b1);
      end
      sto_pkg::CMD_TICK: begin
        if (clock_now < TIME_MAX) clock_now++;
        while (fired < sto_pkg::RESULT_CAP && timer_list.size() > 0 &&
               timer_list[0].expiry <= clock_now) begin
          expect_result(sto_pkg::KIND_EXP, timer_list[0].id, sto_pkg::STAT_OK, 1'b0);
          armed[timer_list[0].id] = 1'b0;
          void'(timer_list.pop_front());
          fired++;
        end
        if (fired > 0) expected_results[expected_results.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void enqueue_request(logic [1:0] c, logic [sto_pkg::ID_W-1:0] id,
                                          logic [sto_pkg::DELTA_W-1:0] d);
    sto_pkg::cmd_req_t item;
    item.cmd = c;
    item.timer_id = id;
    item.delta = d;
    cmd_backlog.push_back(item);
  endfunction

  function automatic int draw_pause(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Alternate noisy and quiet stretches
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        apply_command(cmd_req);
        accepted++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cmd_req <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
          gap_left = draw_pause(calm);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Result backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = draw_pause(1'b0);
    end
  end

  task automatic report_mismatch(string what, sto_pkg::res_data_t want,
                                 sto_pkg::res_data_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: %s: expected kind=%0d id=%0d status=%0d last=%0b, ",
                "got kind=%0d id=%0d status=%0d last=%0b"},
               $time, what, want.kind, want.expired_id, want.status, want.last,
               got.kind, got.expired_id, got.status, got.last);
  endtask

  // Result monitor
  always @(posedge clk) begin
    sto_pkg::res_data_t want;
    if (!rst && res_valid && res_ready) begin
      checked++;
      if (res_data.kind == sto_pkg::KIND_EXP) expiries_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, res_data);
      end else begin
        want = expected_results.pop_front();
        if (res_data.kind !== want.kind || res_data.expired_id !== want.expired_id ||
            res_data.status !== want.status || res_data.last !== want.last)
          report_mismatch("result mismatch", want, res_data);
      end
    end
  end

  initial begin
    int made;
    int n;
    logic [1:0] c;
    // Directed: empty tick, spare code, unknown delete, max delta,
    // duplicate add, delete hit, full queue with equal expiry, mass expiry
    enqueue_request(sto_pkg::CMD_TICK, 4'd0, '0);
    enqueue_request(CMD_UNUSED, 4'd15, '1);
    enqueue_request(sto_pkg::CMD_DEL, 4'd5, '0);
    enqueue_request(sto_pkg::CMD_ADD, 4'd3, 32'hFFFF_FFFF);
    enqueue_request(sto_pkg::CMD_ADD, 4'd3, 32'd0);
    enqueue_request(sto_pkg::CMD_DEL, 4'd3, '0);
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      enqueue_request(sto_pkg::CMD_ADD, i[sto_pkg::ID_W-1:0], 32'd0);
    end
    enqueue_request(sto_pkg::CMD_ADD, 4'd9, 32'd0);
    enqueue_request(sto_pkg::CMD_TICK, 4'd0, '0);

    // Random: mostly add bursts followed by ticks, some plain noise
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 75) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          enqueue_request(sto_pkg::CMD_ADD, sto_pkg::ID_W'($urandom_range(0, 15)),
                          ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6));
          made++;
          if ($urandom_range(0, 4) == 0) begin
            enqueue_request(sto_pkg::CMD_DEL, sto_pkg::ID_W'($urandom_range(0, 15)),
                            $urandom);
            made++;
          end
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
          enqueue_request(sto_pkg::CMD_TICK, sto_pkg::ID_W'($urandom_range(0, 15)),
                          $urandom);
          made++;
        end
      end else begin
        c = 2'($urandom_range(0, 3));
        enqueue_request(c, sto_pkg::ID_W'($urandom_range(0, 15)), $urandom);
        if (c != CMD_UNUSED) made++;
      end
    end

    @(negedge clk);
    while (rst || cmd_backlog.size() > 0 || cmd_valid) @(negedge clk);
    while (expected_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Accepted %0d requests, checked %0d results (%0d expiries).",
             accepted, checked, expiries_seen);
    $display("Covered empty ticks, duplicate adds, missed deletes and a full-queue flush.");
    if (mismatches == 0) begin
      $display("sorted_timeout_queue_unit verification clean");
    end else begin
      $display("sorted_timeout_queue_unit verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results still pending.", expected_results.size());
    $display("sorted_timeout_queue_unit verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/sto_pkg.sv
rtl/sto_cell.sv
rtl/sorted_timeout_queue_unit.sv
rtl/sto_check.sv
dv/sorted_timeout_queue_unit_tb.sv
